### rtl/core/irp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package irp_pkg;

  localparam int SIG_W  = 113;
  localparam int EXC_W  = 5;
  localparam int ESUM_W = 19;

  localparam logic [2:0] FUNC_INT32  = 3'd0;
  localparam logic [2:0] FUNC_INT64  = 3'd1;
  localparam logic [2:0] FUNC_SINGLE = 3'd2;
  localparam logic [2:0] FUNC_DOUBLE = 3'd3;
  localparam logic [2:0] FUNC_QUAD   = 3'd4;

  localparam logic [2:0] CLS_ZERO   = 3'd0;
  localparam logic [2:0] CLS_NORMAL = 3'd1;
  localparam logic [2:0] CLS_INF    = 3'd2;
  localparam logic [2:0] CLS_QNAN   = 3'd3;
  localparam logic [2:0] CLS_SNAN   = 3'd4;

  localparam logic [1:0] RM_RNE = 2'd0;
  localparam logic [1:0] RM_RTZ = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam int EXC_INX = 0;
  localparam int EXC_UNF = 2;
  localparam int EXC_OVF = 3;
  localparam int EXC_INV = 4;

  typedef struct packed {
    logic [SIG_W-1:0]         sig;
    logic                     rnd;
    logic                     stk;
    logic signed [ESUM_W-1:0] bexp;
    logic                     int_big;
    logic                     tiny;
  } irp_align_t;

endpackage
`default_nettype wire

### rtl/core/irp_align.sv
`timescale 1ns / 1ps
`default_nettype none
module irp_align import irp_pkg::*; (
  input  logic [2:0]        func,
  input  logic [2:0]        cls,
  input  logic signed [15:0] exponent,
  input  logic [SIG_W-1:0]  sig,
  input  logic              rnd,
  input  logic              stk,
  output irp_align_t        aligned
);

  logic signed [ESUM_W-1:0] ex_w;
  logic signed [ESUM_W-1:0] bexp;
  logic signed [ESUM_W-1:0] bias;
  logic signed [ESUM_W-1:0] fb;
  logic signed [ESUM_W-1:0] n_raw;
  logic                     is_flt;
  logic                     tiny;
  logic                     int_big;
  logic [6:0]               n;
  logic [6:0]               nm1;
  logic [127:0]             ext;
  logic [127:0]             shifted;
  logic [127:0]             mask;

  always_comb begin
    ex_w    = ESUM_W'(exponent);
    bias    = '0;
    fb      = '0;
    is_flt  = 1'b0;
    int_big = 1'b0;
    n_raw   = '0;
    case (func)
      FUNC_INT32: begin
        n_raw   = 19'sd112 - ex_w;
        int_big = ex_w >= 19'sd32;
      end
      FUNC_INT64: begin
        n_raw   = 19'sd112 - ex_w;
        int_big = ex_w >= 19'sd64;
      end
      FUNC_SINGLE: begin
        is_flt = 1'b1;
        bias   = 19'sd127;
        fb     = 19'sd23;
      end
      FUNC_DOUBLE: begin
        is_flt = 1'b1;
        bias   = 19'sd1023;
        fb     = 19'sd52;
      end
      FUNC_QUAD: begin
        is_flt = 1'b1;
        bias   = 19'sd16383;
        fb     = 19'sd112;
      end
      default: begin
      end
    endcase
    bexp = ex_w + bias;
    tiny = is_flt && (bexp <= 19'sd0);
    if (is_flt) begin
      if (cls == CLS_NORMAL) begin
        // a tiny value folds the denormal shift into the format shift
        n_raw = tiny ? (19'sd113 - fb - bexp) : (19'sd112 - fb);
      end else if (cls == CLS_QNAN || cls == CLS_SNAN) begin
        n_raw = 19'sd112 - fb;
      end else begin
        n_raw = '0;
      end
    end
    if (n_raw < 19'sd0) begin
      n = '0;
    end else if (n_raw > 19'sd127) begin
      n = 7'd127;
    end else begin
      n = n_raw[6:0];
    end
    ext     = {15'b0, sig};
    shifted = ext >> n;
    nm1     = n - 7'd1;
    mask    = (128'd1 << nm1) - 128'd1;
    aligned.sig     = shifted[SIG_W-1:0];
    aligned.bexp    = bexp;
    aligned.tiny    = tiny;
    aligned.int_big = int_big;
    if (n == 7'd0) begin
      aligned.rnd = rnd;
      aligned.stk = stk;
    end else begin
      aligned.rnd = ext[nm1];
      aligned.stk = stk | rnd | (|(ext & mask));
    end
  end

endmodule
`default_nettype wire

### rtl/core/ieee_round_and_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// IEEE round and pack.
// Input channel: an item (target format, class, sign, exponent, 113-bit
// significand, round/sticky bits, prior flags) is taken at a rising edge
// with start high and busy low. busy is always low: one item per cycle.
// Result channel: packed bits, flags and write enable pass the input and
// aligned registers and are loaded into the result registers. They stay on
// the result ports for one cycle with done high, and are taken then.
// Pipeline: input register, alignment shift register, round/pack register.
// The 128-bit barrel shift and the 114-bit round increment each own a stage.
// Throughput is one item per cycle; the receiver cannot stall, so nothing
// holds back the pipe.
// Config: cfg_write with cfg_index 0 sets rounding_mode, 1 sets
// trap_enable, from cfg_data; write only while no item is in flight.
// Reset (rst, synchronous) clears both registers and all valid bits.
module ieee_round_and_pack import irp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data,
  input  logic [2:0]        func,
  input  logic [2:0]        value_class,
  input  logic              sign,
  input  logic signed [15:0] exponent,
  input  logic [48:0]       significand_high,
  input  logic [63:0]       significand_low,
  input  logic              round_bit,
  input  logic              sticky_bit,
  input  logic [4:0]        prior_exceptions,
  output logic              done,
  output logic [63:0]       result_high,
  output logic [63:0]       result_low,
  output logic [4:0]        exceptions,
  output logic              write_enable
);

  localparam logic REG_RM = 1'b0;
  localparam logic REG_TE = 1'b1;

  logic [1:0]        rounding_mode;
  logic [4:0]        trap_enable;

  // input register
  logic              s0_valid;
  logic [2:0]        s0_func;
  logic [2:0]        s0_cls;
  logic              s0_sign;
  logic signed [15:0] s0_exp;
  logic [SIG_W-1:0]  s0_sig;
  logic              s0_rnd;
  logic              s0_stk;
  logic [4:0]        s0_exc;

  // aligned register
  logic              s1_valid;
  logic [2:0]        s1_func;
  logic [2:0]        s1_cls;
  logic              s1_sign;
  logic [4:0]        s1_exc;
  irp_align_t        s1_al;
  irp_align_t        al_next;

  // round and pack
  logic              inexact;
  logic              inc;
  logic [SIG_W:0]    sum;
  logic [4:0]        exc_r;
  logic [SIG_W:0]    lim;
  logic [63:0]       ival;
  logic [SIG_W:0]    pow_fb;
  logic [SIG_W:0]    pow_fb1;
  logic [111:0]      frac_mask;
  logic signed [ESUM_W-1:0] emax;
  logic signed [ESUM_W-1:0] e1;
  logic [14:0]       e_out;
  logic [111:0]      frac;
  logic              to_inf;
  logic [63:0]       rh_next;
  logic [63:0]       rl_next;
  logic [4:0]        exc_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= RM_RNE;
      trap_enable   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_RM) begin
        rounding_mode <= cfg_data[1:0];
      end else if (cfg_index == REG_TE) begin
        trap_enable <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_func <= func;
    // undefined class codes behave as zero
    s0_cls  <= (value_class > CLS_SNAN) ? CLS_ZERO : value_class;
    s0_sign <= sign;
    s0_exp  <= exponent;
    s0_sig  <= {significand_high, significand_low};
    s0_rnd  <= round_bit;
    s0_stk  <= sticky_bit;
    s0_exc  <= prior_exceptions;
    s1_func <= s0_func;
    s1_cls  <= s0_cls;
    s1_sign <= s0_sign;
    s1_exc  <= s0_exc;
    s1_al   <= al_next;
    result_high  <= rh_next;
    result_low   <= rl_next;
    exceptions   <= exc_next;
    write_enable <= (exc_next & trap_enable) == 5'd0;
  end

  irp_align u_align (
    .func     (s0_func),
    .cls      (s0_cls),
    .exponent (s0_exp),
    .sig      (s0_sig),
    .rnd      (s0_rnd),
    .stk      (s0_stk),
    .aligned  (al_next)
  );

  always_comb begin
    inexact = s1_al.rnd | s1_al.stk;
    case (rounding_mode)
      RM_RNE:  inc = s1_al.rnd;
      RM_RTZ:  inc = 1'b0;
      RM_RUP:  inc = ~s1_sign;
      default: inc = s1_sign;
    endcase
    inc = inc & inexact;
    case (rounding_mode)
      RM_RNE:  to_inf = 1'b1;
      RM_RTZ:  to_inf = 1'b0;
      RM_RUP:  to_inf = ~s1_sign;
      default: to_inf = s1_sign;
    endcase
    sum = {1'b0, s1_al.sig} + {{SIG_W{1'b0}}, inc};
    // ties to even: an exact half drops the low bit
    if (rounding_mode == RM_RNE && inc && !s1_al.stk) begin
      sum[0] = 1'b0;
    end
    exc_r = s1_exc;
    exc_r[EXC_INX] = s1_exc[EXC_INX] | inexact;

    lim = (s1_func == FUNC_INT32) ? (114'd1 << 31) : (114'd1 << 63);
    ival = s1_sign ? (64'd0 - sum[63:0]) : sum[63:0];

    pow_fb    = '0;
    frac_mask = '0;
    emax      = '0;
    case (s1_func)
      FUNC_SINGLE: begin
        pow_fb = 114'd1 << 23;
        emax   = 19'sd255;
      end
      FUNC_DOUBLE: begin
        pow_fb = 114'd1 << 52;
        emax   = 19'sd2047;
      end
      default: begin
        pow_fb = 114'd1 << 112;
        emax   = 19'sd32767;
      end
    endcase
    pow_fb1   = pow_fb << 1;
    frac_mask = pow_fb[111:0] - 112'd1;

    e1       = s1_al.bexp + ((sum == pow_fb1) ? 19'sd1 : 19'sd0);
    e_out    = '0;
    frac     = '0;
    rh_next  = '0;
    rl_next  = '0;
    exc_next = s1_exc;

    case (s1_func)
      FUNC_INT32, FUNC_INT64: begin
        if (s1_cls == CLS_ZERO) begin
          rh_next = '0;
        end else if (s1_cls == CLS_NORMAL && !s1_al.int_big &&
                     !(sum > lim || (sum == lim && !s1_sign))) begin
          rh_next  = (s1_func == FUNC_INT32) ? {32'b0, ival[31:0]} : ival;
          exc_next = exc_r;
        end else begin
          // saturate and flag invalid; inexact never stands beside invalid
          rh_next = s1_sign ? lim[63:0] : (lim[63:0] - 64'd1);
          exc_next[EXC_INX] = 1'b0;
          exc_next[EXC_INV] = 1'b1;
        end
      end
      FUNC_SINGLE, FUNC_DOUBLE, FUNC_QUAD: begin
        if (s1_cls == CLS_INF) begin
          e_out = emax[14:0];
        end else if (s1_cls == CLS_QNAN || s1_cls == CLS_SNAN) begin
          // quiet bit forced, top payload kept
          e_out = emax[14:0];
          frac  = (s1_al.sig[111:0] & (frac_mask >> 1)) | pow_fb[112:1];
        end else if (s1_cls == CLS_NORMAL && s1_al.tiny) begin
          exc_next = exc_r;
          if (sum == pow_fb) begin
            e_out = 15'd1;
            exc_next[EXC_INX] = 1'b1;
          end else begin
            frac = sum[111:0] & frac_mask;
          end
          if (exc_next[EXC_INX]) begin
            exc_next[EXC_UNF] = 1'b1;
          end
          if (trap_enable[EXC_UNF]) begin
            exc_next[EXC_UNF] = 1'b1;
            exc_next[EXC_INX] = 1'b0;
          end
        end else if (s1_cls == CLS_NORMAL) begin
          exc_next = exc_r;
          if (e1 >= emax) begin
            exc_next[EXC_OVF] = 1'b1;
            exc_next[EXC_INX] = ~trap_enable[EXC_OVF];
            if (to_inf) begin
              e_out = emax[14:0];
            end else begin
              e_out = emax[14:0] - 15'd1;
              frac  = frac_mask;
            end
          end else begin
            e_out = e1[14:0];
            frac  = sum[111:0] & frac_mask;
          end
        end
        case (s1_func)
          FUNC_SINGLE: rh_next = {32'b0, s1_sign, e_out[7:0], frac[22:0]};
          FUNC_DOUBLE: rh_next = {s1_sign, e_out[10:0], frac[51:0]};
          default: begin
            rh_next = {s1_sign, e_out, frac[111:64]};
            rl_next = frac[63:0];
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import irp_pkg::*;

  // One packer input item and one packed result.
  typedef struct {
    logic [2:0]  func;
    logic [2:0]  cls;
    logic        sgn;
    logic [15:0] expo;
    logic [48:0] sig_hi;
    logic [63:0] sig_lo;
    logic        rnd;
    logic        stk;
    logic [4:0]  prior;
  } pack_item_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  exc;
    logic        we;
  } pack_res_t;

  // Directed row: the item plus an optional hand-typed expectation.
  typedef struct {
    pack_item_t  item;
    bit          typed;
    pack_res_t   res;
  } row_t;

  localparam int CLK_HALF  = 4;
  localparam int PIPE_LAT  = 3;
  localparam int WD_LIMIT  = 5000;
  localparam int N_RANDOM  = 430;

  localparam logic [0:0] REG_RMODE = 1'b0;
  localparam logic [0:0] REG_TRAPS = 1'b1;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_write;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  logic [2:0]  func;
  logic [2:0]  value_class;
  logic        sign;
  logic signed [15:0] exponent;
  logic [48:0] significand_high;
  logic [63:0] significand_low;
  logic        round_bit;
  logic        sticky_bit;
  logic [4:0]  prior_exceptions;
  logic        done;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  exceptions;
  logic        write_enable;

  ieee_round_and_pack u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (func),
    .value_class      (value_class),
    .sign             (sign),
    .exponent         (exponent),
    .significand_high (significand_high),
    .significand_low  (significand_low),
    .round_bit        (round_bit),
    .sticky_bit       (sticky_bit),
    .prior_exceptions (prior_exceptions),
    .done             (done),
    .result_high      (result_high),
    .result_low       (result_low),
    .exceptions       (exceptions),
    .write_enable     (write_enable)
  );

  // Shadow copies of the two config registers, as seen by the packer.
  logic [1:0]  rmode_shadow;
  logic [4:0]  traps_shadow;

  pack_res_t   packed_q[$];   // results still owed by the pipe
  int          err_cnt;
  int          quiet_cycles;
  bit          idle_on;
  bit          row_typed;     // item on the ports carries a typed expectation
  pack_res_t   row_res;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor. Works on a 128-bit significand with separate guard (round)
  // and sticky bits; the shadow mode and trap mask drive rounding.
  // ---------------------------------------------------------------------

  // Right shift that folds everything shifted out into round/sticky.
  function automatic void sig_shift(inout logic [127:0] w, inout logic r,
                                    inout logic s, input int unsigned n);
    logic nr;
    logic any;
    if (n == 0) return;
    nr = (n - 1 < 128) ? w[n-1] : 1'b0;
    if (n - 1 == 0) any = 1'b0;
    else if (n - 1 >= 128) any = |w;
    else any = |(w & ((128'd1 << (n - 1)) - 128'd1));
    s = s | r | any;
    r = nr;
    w = (n >= 128) ? 128'd0 : (w >> n);
  endfunction

  function automatic void sig_round(inout logic [127:0] w, input logic r,
                                    input logic s, input logic sg,
                                    inout logic [4:0] exc);
    logic inc;
    if (!(r | s)) return;
    exc[EXC_INX] = 1'b1;
    case (rmode_shadow)
      RM_RNE: inc = r;
      RM_RTZ: inc = 1'b0;
      RM_RUP: inc = ~sg;
      default: inc = sg;
    endcase
    if (inc) begin
      w = w + 128'd1;
      // tie in nearest-even: drop the lsb back to even
      if (rmode_shadow == RM_RNE && !s) w[0] = 1'b0;
    end
  endfunction

  function automatic logic [127:0] low_mask(input int unsigned k);
    return (128'd1 << k) - 128'd1;
  endfunction

  function automatic pack_res_t predict_pack(input pack_item_t it);
    pack_res_t   o;
    logic [127:0] w;
    logic        r;
    logic        s;
    logic [2:0]  cls;
    logic [4:0]  exc;
    int          ex;
    int          bits;
    int unsigned fb;
    int unsigned ew;
    int          bias;
    int          emax;
    int          e;
    logic [63:0] lim;
    logic [63:0] msk;
    logic [63:0] ef;
    bit          sat;
    w   = {15'd0, it.sig_hi, it.sig_lo};
    r   = it.rnd;
    s   = it.stk;
    cls = (it.cls > CLS_SNAN) ? CLS_ZERO : it.cls;
    exc = it.prior;
    ex  = $signed(it.expo);
    o.hi = '0;
    o.lo = '0;
    if (it.func == FUNC_INT32 || it.func == FUNC_INT64) begin
      bits = (it.func == FUNC_INT32) ? 32 : 64;
      lim  = 64'd1 << (bits - 1);
      msk  = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
      sat  = 1'b1;
      if (cls == CLS_ZERO) sat = 1'b0;
      else if (cls == CLS_NORMAL && ex < bits) begin
        sig_shift(w, r, s, 112 - ex);
        sig_round(w, r, s, it.sgn, exc);
        if (!(w[127:64] != 0 || w[63:0] > lim || (w[63:0] == lim && !it.sgn))) begin
          sat  = 1'b0;
          o.hi = (it.sgn ? (64'd0 - w[63:0]) : w[63:0]) & msk;
        end
      end
      if (sat) begin
        o.hi = it.sgn ? lim : lim - 64'd1;
        exc[EXC_INX] = 1'b0;
        exc[EXC_INV] = 1'b1;
      end
    end else if (it.func <= FUNC_QUAD) begin
      case (it.func)
        FUNC_SINGLE: begin fb = 23;  ew = 8;  bias = 127;   emax = 'hff;   end
        FUNC_DOUBLE: begin fb = 52;  ew = 11; bias = 1023;  emax = 'h7ff;  end
        default:     begin fb = 112; ew = 15; bias = 16383; emax = 'h7fff; end
      endcase
      e = 0;
      if (cls == CLS_ZERO) w = '0;
      else if (cls == CLS_INF) begin
        w = '0;
        e = emax;
      end else if (cls == CLS_QNAN || cls == CLS_SNAN) begin
        // quiet bit forced, top payload kept
        sig_shift(w, r, s, 112 - fb);
        w = (w & low_mask(fb - 1)) | (128'd1 << (fb - 1));
        e = emax;
      end else begin
        sig_shift(w, r, s, 112 - fb);
        e = ex + bias;
        if (e <= 0) begin
          // tiny: denormalize, may round back up to the smallest normal
          sig_shift(w, r, s, 1 - e);
          sig_round(w, r, s, it.sgn, exc);
          if (w == (128'd1 << fb)) begin
            e = 1;
            w = '0;
            exc[EXC_INX] = 1'b1;
          end else begin
            e = 0;
            w = w & low_mask(fb);
          end
          if (exc[EXC_INX]) exc[EXC_UNF] = 1'b1;
          if (traps_shadow[EXC_UNF]) begin
            exc[EXC_UNF] = 1'b1;
            exc[EXC_INX] = 1'b0;
          end
        end else begin
          sig_round(w, r, s, it.sgn, exc);
          if (w == (128'd1 << (fb + 1))) begin
            w = 128'd1 << fb;
            e++;
          end
          if (e >= emax) begin
            exc[EXC_OVF] = 1'b1;
            exc[EXC_INX] = 1'b1;
            if (traps_shadow[EXC_OVF]) exc[EXC_INX] = 1'b0;
            // infinity or largest finite, by mode and sign
            if (rmode_shadow == RM_RNE || (rmode_shadow == RM_RUP && !it.sgn) ||
                (rmode_shadow == RM_RDN && it.sgn)) begin
              e = emax;
              w = '0;
            end else begin
              e = emax - 1;
              w = low_mask(fb);
            end
          end else w = w & low_mask(fb);
        end
      end
      ef = 64'(e) & ((64'd1 << ew) - 64'd1);
      if (fb >= 64) begin
        o.hi = (64'(it.sgn) << 63) | (ef << (fb - 64)) | w[127:64];
        o.lo = w[63:0];
      end else begin
        o.hi = (64'(it.sgn) << (ew + fb)) | (ef << fb) | w[63:0];
        o.lo = '0;
      end
    end
    o.exc = exc;
    o.we  = ((exc & traps_shadow) == 5'd0);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: queue an expectation (typed or predicted) on each accepted item, check each done strobe.
  // Inputs only move on the falling edge, so rising-edge reads are stable.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pack_item_t it;
    pack_res_t  want;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        it.func   = func;
        it.cls    = value_class;
        it.sgn    = sign;
        it.expo   = exponent;
        it.sig_hi = significand_high;
        it.sig_lo = significand_low;
        it.rnd    = round_bit;
        it.stk    = sticky_bit;
        it.prior  = prior_exceptions;
        packed_q.push_back(row_typed ? row_res : predict_pack(it));
        moved = 1'b1;
      end
      if (done) begin
        moved = 1'b1;
        if (packed_q.size() == 0) begin
          $display("%0t: result with nothing expected: hi=%h lo=%h exc=%b we=%b",
                   $time, result_high, result_low, exceptions, write_enable);
          err_cnt++;
        end else begin
          want = packed_q.pop_front();
          if (result_high !== want.hi) begin
            $display("%0t: result_high expected %h actual %h", $time, want.hi, result_high);
            err_cnt++;
          end
          if (result_low !== want.lo) begin
            $display("%0t: result_low expected %h actual %h", $time, want.lo, result_low);
            err_cnt++;
          end
          if (exceptions !== want.exc) begin
            $display("%0t: exceptions expected %b actual %b", $time, want.exc, exceptions);
            err_cnt++;
          end
          if (write_enable !== want.we) begin
            $display("%0t: write_enable expected %b actual %b", $time, want.we,
                     write_enable);
            err_cnt++;
          end
        end
      end
      // watchdog: a stuck handshake or a lost result ends the run
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Present one item; returns once it has been taken.
  task automatic send_item(input pack_item_t it, input bit typed, input pack_res_t res);
    while (idle_on && $urandom_range(99) < 25) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    func             = it.func;
    value_class      = it.cls;
    sign             = it.sgn;
    exponent         = it.expo;
    significand_high = it.sig_hi;
    significand_low  = it.sig_lo;
    round_bit        = it.rnd;
    sticky_bit       = it.stk;
    prior_exceptions = it.prior;
    row_typed        = typed;
    row_res          = res;
    start            = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and let the pipe drain before touching config.
  task automatic drain_pipe();
    @(negedge clk);
    start = 1'b0;
    while (packed_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == REG_RMODE) rmode_shadow = val[1:0];
    else traps_shadow = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic pack_item_t mk_item(input logic [2:0] f, input logic [2:0] c,
                                         input logic sg, input int ex,
                                         input logic [48:0] hi, input logic [63:0] lo,
                                         input logic r, input logic s,
                                         input logic [4:0] pe);
    pack_item_t it;
    it.func   = f;
    it.cls    = c;
    it.sgn    = sg;
    it.expo   = 16'(ex);
    it.sig_hi = hi;
    it.sig_lo = lo;
    it.rnd    = r;
    it.stk    = s;
    it.prior  = pe;
    return it;
  endfunction

  // Random item: mostly normals with exponents near the target's edges,
  // some full-range noise in every field.
  function automatic pack_item_t rand_item();
    pack_item_t it;
    int         ex;
    int         pick;
    it.func = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    pick    = $urandom_range(99);
    if (pick < 75) it.cls = CLS_NORMAL;
    else if (pick < 95) it.cls = 3'($urandom_range(4));
    else it.cls = 3'($urandom_range(7));
    it.sgn    = 1'($urandom_range(1));
    it.sig_hi = 49'({$urandom, $urandom});
    it.sig_lo = {$urandom, $urandom};
    if ($urandom_range(9) != 0) it.sig_hi[48] = 1'b1;
    if ($urandom_range(3) == 0) it.sig_lo = $urandom_range(1) ? '1 : '0;
    it.rnd   = 1'($urandom_range(1));
    it.stk   = 1'($urandom_range(1));
    it.prior = $urandom_range(3) == 0 ? 5'($urandom) : 5'd0;
    case (it.func)
      FUNC_INT32:  ex = $urandom_range(36) - 4;
      FUNC_INT64:  ex = $urandom_range(70) - 4;
      FUNC_SINGLE: ex = ($urandom_range(1)) ? $urandom_range(30) - 155 : $urandom_range(8) + 122;
      FUNC_DOUBLE: ex = ($urandom_range(1)) ? $urandom_range(60) - 1080 : $urandom_range(8) + 1018;
      default:     ex = ($urandom_range(1)) ? $urandom_range(120) - 16500 : $urandom_range(8) + 16378;
    endcase
    if ($urandom_range(9) == 0) ex = $signed(16'($urandom));
    it.expo = 16'(ex);
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    row_t       rows[$];
    row_t       rw;
    pack_res_t  none;
    logic [1:0] mode_seq[4];
    logic [4:0] trap_seq[4];
    int         n;

    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_RMODE;
    cfg_data = '0;
    func = FUNC_INT32;
    value_class = CLS_ZERO;
    sign = 1'b0;
    exponent = '0;
    significand_high = '0;
    significand_low = '0;
    round_bit = 1'b0;
    sticky_bit = 1'b0;
    prior_exceptions = '0;
    rmode_shadow = RM_RNE;
    traps_shadow = '0;
    err_cnt = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    row_typed = 1'b0;
    none = '{hi: '0, lo: '0, exc: '0, we: 1'b1};
    row_res = none;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows, run with the reset config (nearest even, no traps).
    // Typed rows: zeros, infinities, nans, saturation, plain powers of two, undefined codes.
    rw.typed = 1'b1;
    rw.item = mk_item(FUNC_INT32, CLS_ZERO, 1, 0, '0, '0, 0, 0, 0);
    rw.res = none;                                         rows.push_back(rw);
    rw.item = mk_item(FUNC_INT32, CLS_INF, 0, 0, '0, '0, 0, 0, 0);
    rw.res = '{64'h7fffffff, '0, 5'h10, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(FUNC_INT64, CLS_QNAN, 1, 0, '0, '0, 0, 0, 5'h01);
    rw.res = '{64'h8000000000000000, '0, 5'h10, 1'b1};     rows.push_back(rw);
    rw.item = mk_item(FUNC_INT32, CLS_NORMAL, 0, 0, 49'h1 << 48, '0, 0, 0, 0);
    rw.res = '{64'h1, '0, 5'h00, 1'b1};                    rows.push_back(rw);
    rw.item = mk_item(FUNC_INT32, CLS_NORMAL, 1, 31, 49'h1 << 48, '0, 0, 0, 0);
    rw.res = '{64'h80000000, '0, 5'h00, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(FUNC_INT32, CLS_NORMAL, 0, 31, 49'h1 << 48, '0, 0, 0, 0);
    rw.res = '{64'h7fffffff, '0, 5'h10, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(FUNC_SINGLE, CLS_INF, 0, 0, '0, '0, 0, 0, 0);
    rw.res = '{64'h7f800000, '0, 5'h00, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(FUNC_DOUBLE, CLS_INF, 1, 0, '0, '0, 0, 0, 0);
    rw.res = '{64'hfff0000000000000, '0, 5'h00, 1'b1};     rows.push_back(rw);
    rw.item = mk_item(FUNC_QUAD, CLS_ZERO, 1, 0, '1, '1, 1, 1, 0);
    rw.res = '{64'h8000000000000000, '0, 5'h00, 1'b1};     rows.push_back(rw);
    rw.item = mk_item(FUNC_SINGLE, CLS_SNAN, 0, 0, '0, '0, 0, 0, 0);
    rw.res = '{64'h7fc00000, '0, 5'h00, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(FUNC_SINGLE, CLS_NORMAL, 0, -127, 49'h1 << 48, '0, 0, 0, 0);
    rw.res = '{64'h00400000, '0, 5'h00, 1'b1};             rows.push_back(rw);
    rw.item = mk_item(3'd6, CLS_NORMAL, 1, 5, '1, '1, 1, 1, 5'h1f);
    rw.res = '{'0, '0, 5'h1f, 1'b1};                       rows.push_back(rw);
    rw.item = mk_item(FUNC_QUAD, 3'd7, 0, 0, '1, '1, 0, 0, 0);
    rw.res = none;                                         rows.push_back(rw);
    // Predicted rows: rounding carries, denormal back to normal, overflow,
    // exponent extremes, undefined codes.
    rw.typed = 1'b0;
    rw.item = mk_item(FUNC_SINGLE, CLS_NORMAL, 0, -127, '1, '1, 1, 1, 0);   rows.push_back(rw);
    rw.item = mk_item(FUNC_SINGLE, CLS_NORMAL, 1, -160, '1, '0, 0, 1, 0);   rows.push_back(rw);
    rw.item = mk_item(FUNC_SINGLE, CLS_NORMAL, 0, 127, '1, '1, 1, 1, 0);    rows.push_back(rw);
    rw.item = mk_item(FUNC_DOUBLE, CLS_NORMAL, 1, 1023, '1, '1, 1, 1, 0);   rows.push_back(rw);
    rw.item = mk_item(FUNC_QUAD, CLS_NORMAL, 0, 16383, '1, '1, 1, 1, 0);    rows.push_back(rw);
    rw.item = mk_item(FUNC_QUAD, CLS_NORMAL, 1, -32768, '1, '1, 1, 1, 0);   rows.push_back(rw);
    rw.item = mk_item(FUNC_DOUBLE, CLS_NORMAL, 0, 32767, '1, '1, 0, 0, 0);  rows.push_back(rw);
    rw.item = mk_item(FUNC_INT64, CLS_NORMAL, 0, 62, '1, '1, 1, 1, 0);      rows.push_back(rw);
    rw.item = mk_item(FUNC_INT32, CLS_NORMAL, 1, -1, '1, '1, 1, 0, 0);      rows.push_back(rw);
    rw.item = mk_item(FUNC_QUAD, CLS_SNAN, 1, 0, '1, '1, 1, 1, 0);          rows.push_back(rw);
    rw.item = mk_item(3'd5, 3'd5, 0, -1, '1, '1, 1, 1, 5'h0a);              rows.push_back(rw);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    // Random part: sweep the rounding modes against several trap masks,
    // including none and all.
    mode_seq = '{RM_RNE, RM_RTZ, RM_RUP, RM_RDN};
    trap_seq = '{5'h00, 5'h1f, 5'h04, 5'h09};
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_pipe();
      write_reg(REG_RMODE, 5'(mode_seq[ph % 4]));
      write_reg(REG_TRAPS, (ph < 4) ? trap_seq[ph] : 5'($urandom));
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        // a stretch of back-to-back items in the second phase
        idle_on = !(ph == 1);
        if (ph == 5 && k == 20) begin
          // let every owed result come home mid-phase
          @(negedge clk);
          start = 1'b0;
          while (packed_q.size() != 0) @(posedge clk);
        end
        send_item(rand_item(), 1'b0, none);
        n++;
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (packed_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
